>>> rtl/mdu_pkg.sv
package mdu_pkg;

    // Restoring divide: one quotient bit per step
    localparam int unsigned QUO_BITS        = 16;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES      = QUO_BITS / STEPS_PER_STAGE;

    // Flag update codes
    localparam logic [1:0] UPD_ALL  = 2'd0;
    localparam logic [1:0] UPD_V    = 2'd1;
    localparam logic [1:0] UPD_NONE = 2'd2;

    // Outcome decided ahead of the divide
    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_OVF    = 2'd1,
        KIND_DZ     = 2'd2,
        KIND_MINNEG = 2'd3
    } mdu_kind_t;

    typedef struct packed {
        mdu_kind_t   kind;
        logic        sgn_op;
        logic        qneg;
        logic        dneg;
        logic [15:0] smag;
        logic [15:0] rem;
        logic [15:0] quo;
        logic [31:0] dividend;
    } mdu_work_t;

endpackage

>>> rtl/m68k_divide_unit.sv
// 32 / 16 divide, unsigned or signed (DIVU/DIVS style), fully pipelined.
// Throughput: one word per cycle; s_tready follows m_tready through the stage chain.
// Stages: operand prep, four restoring stages of four quotient bits each
// (16 bits total), then sign fix and flag stage.
// Reset: aresetn (synchronous, active low) clears every stage valid; data regs keep contents.
module m68k_divide_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] divisor, [47:16] dividend
    input  logic [0:0]  s_tuser,   // [0] action (1 = signed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] result, [32] zero_flag, [33] negative_flag,
                                   // [34] overflow_flag, [35] carry_flag,
                                   // [37:36] flag_update, [38] divide_by_zero, [39] zero pad
);
    import mdu_pkg::*;

    // Handshake and payload between stages: index 0 is the prep output,
    // index DIV_STAGES the last divide stage output.
    logic      stg_valid [DIV_STAGES+1];
    logic      stg_ready [DIV_STAGES+1];
    mdu_work_t stg_data  [DIV_STAGES+1];

    logic [31:0] res_result;
    logic        res_z;
    logic        res_n;
    logic        res_v;
    logic        res_c;
    logic [1:0]  res_upd;
    logic        res_dz;

    // Stage 0: magnitudes and early outcome (zero divisor, overflow, min/-1)
    mdu_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (s_tuser[0]),
        .divisor   (s_tdata[15:0]),
        .dividend  (s_tdata[47:16]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Stages 1..DIV_STAGES: restoring divide, four quotient bits per stage
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        mdu_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Last stage: range check, sign fix, flags; also the output register
    mdu_post u_post (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (stg_valid[DIV_STAGES]),
        .in_ready       (stg_ready[DIV_STAGES]),
        .in_data        (stg_data[DIV_STAGES]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result         (res_result),
        .zero_flag      (res_z),
        .negative_flag  (res_n),
        .overflow_flag  (res_v),
        .carry_flag     (res_c),
        .flag_update    (res_upd),
        .divide_by_zero (res_dz)
    );

    assign m_tdata = {1'b0, res_dz, res_upd, res_c, res_v, res_n, res_z, res_result};

endmodule

>>> rtl/mdu_prep.sv
module mdu_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [15:0]       divisor,
    input  logic [31:0]       dividend,
    output logic              out_valid,
    input  logic              out_ready,
    output mdu_pkg::mdu_work_t out_data
);
    import mdu_pkg::*;

    logic      valid_reg;
    mdu_work_t data_reg;
    mdu_work_t data_next;

    always_comb begin
        logic        sneg;
        logic        dneg;
        logic [15:0] smag;
        logic [31:0] dmag;
        sneg = action & divisor[15];
        dneg = action & dividend[31];
        smag = sneg ? 16'(~divisor + 16'd1) : divisor;
        dmag = dneg ? 32'(~dividend + 32'd1) : dividend;

        data_next.sgn_op   = action;
        data_next.qneg     = sneg ^ dneg;
        data_next.dneg     = dneg;
        data_next.smag     = smag;
        data_next.rem      = dmag[31:16];
        data_next.quo      = dmag[15:0];
        data_next.dividend = dividend;
        if (divisor == 16'd0) begin
            data_next.kind = KIND_DZ;
        end else if (action && dividend == 32'h8000_0000 && divisor == 16'hFFFF) begin
            data_next.kind = KIND_MINNEG;
        end else if (dmag[31:16] >= smag) begin
            // quotient would need more than 16 bits
            data_next.kind = KIND_OVF;
        end else begin
            data_next.kind = KIND_NORMAL;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/mdu_step.sv
module mdu_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mdu_pkg::mdu_work_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mdu_pkg::mdu_work_t out_data
);
    import mdu_pkg::*;

    logic      valid_reg;
    mdu_work_t data_reg;
    mdu_work_t data_next;

    // STEPS_PER_STAGE restoring steps; quotient bits shift in at the bottom
    always_comb begin
        logic [16:0] trial;
        logic        qbit;
        data_next = in_data;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            trial = {data_next.rem, data_next.quo[15]};
            qbit  = (trial >= {1'b0, data_next.smag});
            if (qbit) begin
                trial = trial - {1'b0, data_next.smag};
            end
            data_next.rem = trial[15:0];
            data_next.quo = {data_next.quo[14:0], qbit};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/mdu_post.sv
module mdu_post (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mdu_pkg::mdu_work_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       result,
    output logic              zero_flag,
    output logic              negative_flag,
    output logic              overflow_flag,
    output logic              carry_flag,
    output logic [1:0]        flag_update,
    output logic              divide_by_zero
);
    import mdu_pkg::*;

    typedef struct packed {
        logic [31:0] result;
        logic        z;
        logic        n;
        logic        v;
        logic        c;
        logic [1:0]  upd;
        logic        dz;
    } mdu_out_t;

    logic     valid_reg;
    mdu_out_t out_reg;
    mdu_out_t out_next;

    always_comb begin
        logic        fits;
        logic [15:0] qbits;
        logic [15:0] rbits;
        fits  = in_data.qneg ? (in_data.quo <= 16'h8000) : (in_data.quo <= 16'h7FFF);
        fits  = fits || !in_data.sgn_op;
        qbits = in_data.qneg ? 16'(~in_data.quo + 16'd1) : in_data.quo;
        rbits = in_data.dneg ? 16'(~in_data.rem + 16'd1) : in_data.rem;

        out_next.c = 1'b0;
        case (in_data.kind)
            KIND_DZ: begin
                out_next.result = in_data.dividend;
                out_next.z      = 1'b0;
                out_next.n      = 1'b0;
                out_next.v      = 1'b0;
                out_next.upd    = UPD_NONE;
                out_next.dz     = 1'b1;
            end
            KIND_MINNEG: begin
                out_next.result = 32'd0;
                out_next.z      = 1'b1;
                out_next.n      = 1'b0;
                out_next.v      = 1'b0;
                out_next.upd    = UPD_ALL;
                out_next.dz     = 1'b0;
            end
            KIND_NORMAL: begin
                if (fits) begin
                    out_next.result = {rbits, qbits};
                    out_next.z      = (qbits == 16'd0);
                    out_next.n      = qbits[15];
                    out_next.v      = 1'b0;
                    out_next.upd    = UPD_ALL;
                end else begin
                    out_next.result = in_data.dividend;
                    out_next.z      = 1'b0;
                    out_next.n      = 1'b0;
                    out_next.v      = 1'b1;
                    out_next.upd    = UPD_V;
                end
                out_next.dz = 1'b0;
            end
            default: begin
                out_next.result = in_data.dividend;
                out_next.z      = 1'b0;
                out_next.n      = 1'b0;
                out_next.v      = 1'b1;
                out_next.upd    = UPD_V;
                out_next.dz     = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_reg <= out_next;
        end
    end

    assign out_valid      = valid_reg;
    assign result         = out_reg.result;
    assign zero_flag      = out_reg.z;
    assign negative_flag  = out_reg.n;
    assign overflow_flag  = out_reg.v;
    assign carry_flag     = out_reg.c;
    assign flag_update    = out_reg.upd;
    assign divide_by_zero = out_reg.dz;

`ifndef SYNTH
    a_dz_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_reg.dz |-> out_reg.upd == UPD_NONE && !out_reg.v)
        else $error("zero divisor must write no flags");
    a_ovf_only_v: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_reg.upd == UPD_V |-> out_reg.v && !out_reg.z && !out_reg.n)
        else $error("overflow must set V alone");
    a_ok_v_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_reg.upd == UPD_ALL |-> !out_reg.v && !out_reg.dz
            && out_reg.z == (out_reg.result[15:0] == 16'd0)
            && out_reg.n == out_reg.result[15])
        else $error("Z/N do not match quotient");
    a_carry_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !out_reg.c)
        else $error("carry must stay clear");
`endif

endmodule

>>> tb/m68k_divide_checker.sv
`timescale 1ns / 100ps

module m68k_divide_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,     // [15:0] divisor, [47:16] dividend
    input  logic [0:0]  s_tuser,     // [0] action (1 = signed)
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,     // [31:0] result, [32] Z, [33] N, [34] V, [35] C,
                                     // [37:36] flag_update, [38] divide_by_zero
    output int          fail_count,
    output int          words_due
);
    import mdu_pkg::*;

    // same bit order as m_tdata[38:0]
    typedef struct packed {
        logic        dz;
        logic [1:0]  upd;
        logic        c;
        logic        v;
        logic        n;
        logic        z;
        logic [31:0] result;
    } div_out_t;

    div_out_t quotients_due[$];

    initial begin
        fail_count = 0;
        words_due  = 0;
    end

    function automatic div_out_t predict_divide(input logic        is_signed,
                                                input logic [15:0] dvs,
                                                input logic [31:0] dvd);
        div_out_t    o;
        logic        sneg, dneg, qneg, fits;
        logic [31:0] smag, dmag, qmag, rmag, qbits, rbits;
        o = '0;
        if (dvs == 16'd0) begin
            o.result = dvd;
            o.upd    = UPD_NONE;
            o.dz     = 1'b1;
            return o;
        end
        if (!is_signed) begin
            qmag  = dvd / {16'd0, dvs};
            rmag  = dvd % {16'd0, dvs};
            fits  = (qmag < 32'h10000);
            qbits = qmag;
            rbits = rmag;
        end else if (dvd == 32'h8000_0000 && dvs == 16'hFFFF) begin
            // most negative / -1: zero result, Z only
            o.z   = 1'b1;
            o.upd = UPD_ALL;
            return o;
        end else begin
            sneg  = dvs[15];
            dneg  = dvd[31];
            qneg  = sneg ^ dneg;
            smag  = sneg ? (32'h10000 - {16'd0, dvs}) : {16'd0, dvs};
            dmag  = dneg ? (32'd0 - dvd) : dvd;
            qmag  = dmag / smag;
            rmag  = dmag % smag;
            fits  = qneg ? (qmag <= 32'h8000) : (qmag <= 32'h7FFF);
            qbits = qneg ? (32'd0 - qmag) : qmag;
            rbits = dneg ? (32'd0 - rmag) : rmag;
        end
        if (!fits) begin
            o.result = dvd;
            o.v      = 1'b1;
            o.upd    = UPD_V;
            return o;
        end
        o.result = {rbits[15:0], qbits[15:0]};
        o.z      = (qbits[15:0] == 16'd0);
        o.n      = qbits[15];
        o.upd    = UPD_ALL;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        div_out_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                quotients_due.push_back(predict_divide(s_tuser[0], s_tdata[15:0],
                                                       s_tdata[47:16]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[38:0];
                if (quotients_due.size() == 0) begin
                    report_mismatch("word with none pending", got.result, 32'd0);
                end else begin
                    want = quotients_due.pop_front();
                    if (got.result !== want.result)
                        report_mismatch("result", got.result, want.result);
                    if (got.z !== want.z)
                        report_mismatch("zero_flag", 32'(got.z), 32'(want.z));
                    if (got.n !== want.n)
                        report_mismatch("negative_flag", 32'(got.n), 32'(want.n));
                    if (got.v !== want.v)
                        report_mismatch("overflow_flag", 32'(got.v), 32'(want.v));
                    if (got.c !== want.c)
                        report_mismatch("carry_flag", 32'(got.c), 32'(want.c));
                    if (got.upd !== want.upd)
                        report_mismatch("flag_update", 32'(got.upd), 32'(want.upd));
                    if (got.dz !== want.dz)
                        report_mismatch("divide_by_zero", 32'(got.dz), 32'(want.dz));
                end
            end
            words_due = quotients_due.size();
        end
    end

endmodule

>>> tb/m68k_divide_unit_tb.sv
`timescale 1ns / 100ps

module m68k_divide_unit_tb;

    localparam int RANDOM_WORDS = 1650;
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 20;     // pipe is 6 deep; margin on top

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [15:0] divisor, [47:16] dividend
    logic [0:0]  s_tuser;    // [0] action (1 = signed)
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [31:0] result, [32] Z, [33] N, [34] V, [35] C,
                             // [37:36] flag_update, [38] divide_by_zero, [39] pad

    int   fail_count;
    int   words_due;
    int   idle_cycles = 0;
    logic steady = 1'b0;     // when set, neither side inserts gaps

    m68k_divide_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    m68k_divide_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always #10 aclk = ~aclk;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        if (r < 98) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    // Divisor magnitude, biased toward small values so quotients fit
    function automatic int unsigned pick_mag(input int unsigned hi);
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 15);
            1: return $urandom_range(1, 255);
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    // Drive one word at the falling edge, hold until accepted, then maybe idle.
    // Valid is left high when no gap follows, so back-to-back words never
    // drop it within one step.
    task automatic send_word(input logic sgn, input logic [15:0] dvs,
                             input logic [31:0] dvd);
        int gap;
        s_tuser  <= sgn;
        s_tdata  <= {dvd, dvs};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random();
        int unsigned kind, smag, qlim;
        logic        sgn, sneg, dneg;
        logic [15:0] dvs;
        logic [31:0] dvd;
        logic [63:0] qmag, rmag, dmag;
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            // zero divisor
            sgn = 1'($urandom_range(0, 1));
            dvs = 16'd0;
            dvd = $urandom;
        end else if (kind < 28) begin
            // raw operands: mostly overflow, covers every bit
            sgn = 1'($urandom_range(0, 1));
            dvs = 16'($urandom);
            dvd = $urandom;
        end else if (kind < 60) begin
            // unsigned, built from quotient and remainder
            sgn  = 1'b0;
            dvs  = 16'(pick_mag(65535));
            qmag = 64'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) == 0)
                qmag = 64'(65536 + $urandom_range(0, 3));    // just past the limit
            rmag = 64'($urandom_range(0, 32'(dvs) - 1));
            dmag = qmag * 64'(dvs) + rmag;
            dvd  = dmag[31:0];
        end else begin
            // signed, built from magnitudes and signs
            sgn  = 1'b1;
            sneg = 1'($urandom_range(0, 1));
            dneg = 1'($urandom_range(0, 1));
            smag = pick_mag(32768);
            if (smag == 32768)
                sneg = 1'b1;    // +32768 has no 16-bit form
            qlim = (sneg ^ dneg) ? 32768 : 32767;
            qmag = 64'($urandom_range(0, qlim));
            if ($urandom_range(0, 9) == 0)
                qmag = 64'(qlim + 1 + $urandom_range(0, 2));
            rmag = 64'($urandom_range(0, smag - 1));
            dmag = qmag * 64'(smag) + rmag;
            if (dmag > 64'h8000_0000)
                dmag = 64'h8000_0000;
            dvs  = sneg ? 16'(32'h10000 - smag) : 16'(smag);
            dvd  = dneg ? (32'd0 - dmag[31:0]) : dmag[31:0];
        end
        send_word(sgn, dvs, dvd);
    endtask

    // Result side: ready drops at random, independent of valid
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall > 0 && !steady) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = 0;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Watchdog: no progress on either channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // unsigned: zero quotient, largest fitting quotient, first overflow
        send_word(1'b0, 16'h0001, 32'h0000_0000);
        send_word(1'b0, 16'hFFFF, 32'hFFFE_FFFF);
        send_word(1'b0, 16'hFFFF, 32'hFFFF_0000);
        send_word(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(1'b0, 16'h0001, 32'h0000_FFFF);
        send_word(1'b0, 16'h0003, 32'h0000_0007);
        // zero divisor, both forms
        send_word(1'b0, 16'h0000, 32'h0000_0007);
        send_word(1'b0, 16'h0000, 32'hFFFF_FFFF);
        send_word(1'b1, 16'h0000, 32'h8000_0000);
        // most negative by minus one
        send_word(1'b1, 16'hFFFF, 32'h8000_0000);
        // signed overflow around the extremes
        send_word(1'b1, 16'h0001, 32'h8000_0000);
        send_word(1'b1, 16'hFFFF, 32'h7FFF_FFFF);
        send_word(1'b1, 16'h8000, 32'h8000_0000);
        send_word(1'b1, 16'h8000, 32'hC000_0000);
        send_word(1'b1, 16'hFFFE, 32'h8000_0000);
        send_word(1'b1, 16'h0001, 32'h0000_8000);
        // signed quotients at the edges of the range
        send_word(1'b1, 16'h0001, 32'h0000_7FFF);
        send_word(1'b1, 16'h0001, 32'hFFFF_8000);
        send_word(1'b1, 16'h8000, 32'h4000_0000);
        // truncation and remainder sign, all four sign pairs
        send_word(1'b1, 16'h0002, 32'hFFFF_FFF9);
        send_word(1'b1, 16'hFFFE, 32'h0000_0007);
        send_word(1'b1, 16'hFFFE, 32'hFFFF_FFF9);
        send_word(1'b1, 16'h0002, 32'h0000_0007);
        send_word(1'b1, 16'hFFFF, 32'h0000_0000);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // gap-free stretch in every block of 300 words
            steady = (i % 300 >= 150) && (i % 300 < 210);
            if (i == RANDOM_WORDS / 2) begin
                // let the pipe empty completely before going on
                s_tvalid <= 1'b0;
                while (words_due != 0) @(negedge aclk);
            end
            send_random();
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (words_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
